// ===== src/nibble_pixel_unpack_descramble_assert.svh =====
// Assertion macros used by the checker file of the pixel unpacker.
`ifndef NIBBLE_PIXEL_UNPACK_DESCRAMBLE_ASSERT_SVH
`define NIBBLE_PIXEL_UNPACK_DESCRAMBLE_ASSERT_SVH

// Same-cycle implication, sampled on clk, idle while arst_n is low.
`define NPUD_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("npud assertion failed");

// Next-cycle implication, sampled on clk, idle while arst_n is low.
`define NPUD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("npud assertion failed");

`endif

// ===== src/npud_pkg.sv =====
// Shared types, constants and helpers of the nibble pixel unpacker.
package npud_pkg;

	localparam int ADDR_BITS_DEF = 22;
	localparam int NIB_W         = 4;
	localparam int NIBS          = 4;
	localparam int IDX_W         = 2;
	localparam int PIX_W         = 8;
	localparam int BYTE_W        = 8;
	localparam int WORD_W        = 16;
	localparam int DIM_W         = 11;
	localparam int PITCH_W       = 13;
	localparam int COL_W         = 10;
	localparam int ROW_W         = 10;
	localparam int PLANE_W       = 3;
	localparam int LEFT_W        = 21;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 13;
	localparam int COL_STEP      = 4;
	localparam int DIM_MAX       = 1024;
	localparam int QDEPTH        = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WIDTH  = 3'd0,
		CFG_HEIGHT = 3'd1,
		CFG_PITCH  = 3'd2,
		CFG_BASE   = 3'd3,
		CFG_TZ     = 3'd4,
		CFG_DS     = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [DIM_W-1:0]   width;   // clamped to 1..1024
		logic [DIM_W-1:0]   height;  // clamped to 1..1024
		logic [PITCH_W-1:0] pitch;
		logic [PIX_W-1:0]   base;
		logic               tz;
		logic               ds;
	} cfg_t;

	// Four finished pixel values of one word, index 0 goes out first.
	typedef logic [NIBS-1:0][PIX_W-1:0] pix_set_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > DIM_W'(DIM_MAX)) begin
			r = DIM_W'(DIM_MAX);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// ===== src/npud_cfg.sv =====
// Configuration register file with write channel and image size product.
module npud_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [npud_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [npud_pkg::CFG_DATA_W-1:0]     cfg_data,
	output npud_pkg::cfg_t                      cfg,
	output logic [npud_pkg::LEFT_W-1:0]         wh
);

	npud_pkg::cfg_t                    cfg_q;
	logic [npud_pkg::LEFT_W-1:0]       wh_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;
	assign wh        = wh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= npud_pkg::DIM_W'(16);
			cfg_q.height <= npud_pkg::DIM_W'(16);
			cfg_q.pitch  <= npud_pkg::PITCH_W'(16);
			cfg_q.base   <= npud_pkg::PIX_W'(1);
			cfg_q.tz     <= 1'b0;
			cfg_q.ds     <= 1'b0;
			wh_q         <= npud_pkg::LEFT_W'(256);
		end else begin
			// keep the pixel count fresh, updated in the cycle after the dimensions change
			wh_q <= npud_pkg::LEFT_W'(cfg_q.width) * npud_pkg::LEFT_W'(cfg_q.height);
			if (cfg_valid) begin
				case (npud_pkg::cfg_idx_t'(cfg_index))
					npud_pkg::CFG_WIDTH: begin
						cfg_q.width <= npud_pkg::clamp_dim(cfg_data[npud_pkg::DIM_W-1:0]);
					end
					npud_pkg::CFG_HEIGHT: begin
						cfg_q.height <= npud_pkg::clamp_dim(cfg_data[npud_pkg::DIM_W-1:0]);
					end
					npud_pkg::CFG_PITCH: begin
						cfg_q.pitch <= cfg_data[npud_pkg::PITCH_W-1:0];
					end
					npud_pkg::CFG_BASE: begin
						cfg_q.base <= cfg_data[npud_pkg::PIX_W-1:0];
					end
					npud_pkg::CFG_TZ: begin
						cfg_q.tz <= cfg_data[0];
					end
					npud_pkg::CFG_DS: begin
						cfg_q.ds <= cfg_data[0];
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

// ===== src/npud_front.sv =====
// Front end: takes input words and turns their nibbles into palette indices.
module npud_front (
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [npud_pkg::WORD_W-1:0]       s_tdata,
	input  npud_pkg::cfg_t                    cfg,
	output logic                              push,
	output npud_pkg::pix_set_t                push_data,
	input  logic                              q_full
);

	logic [npud_pkg::NIB_W-1:0] nib;

	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;

	// high byte high nibble first, low byte low nibble last
	always_comb begin
		nib = '0;
		for (int i = 0; i < npud_pkg::NIBS; i++) begin
			nib = s_tdata[npud_pkg::WORD_W-1-npud_pkg::NIB_W*i -: npud_pkg::NIB_W];
			if (cfg.tz && nib == '0) begin
				push_data[i] = '0;
			end else begin
				push_data[i] = npud_pkg::PIX_W'(npud_pkg::PIX_W'(nib) + cfg.base
					- npud_pkg::PIX_W'(1));
			end
		end
	end

endmodule

// ===== src/npud_queue.sv =====
// Two-entry word queue between the front end and the address walker.
module npud_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  npud_pkg::pix_set_t   push_data,
	output logic                 full,
	input  logic                 pop,
	output logic                 head_valid,
	output npud_pkg::pix_set_t   head_data
);

	npud_pkg::pix_set_t          mem_q [npud_pkg::QDEPTH];
	logic                        wr_ptr_q;
	logic                        rd_ptr_q;
	logic [1:0]                  cnt_q;

	assign full       = (cnt_q == 2'(npud_pkg::QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== src/npud_back.sv =====
// Back end: walks raster or plane addresses and emits one pixel per cycle while a word is queued and o_ready allows.
module npud_back #(
	parameter int ADDR_BITS = npud_pkg::ADDR_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  npud_pkg::cfg_t                    cfg,
	input  logic [npud_pkg::LEFT_W-1:0]       wh,
	input  logic                              q_valid,
	input  npud_pkg::pix_set_t                q_data,
	output logic                              q_pop,
	output logic                              o_valid,
	input  logic                              o_ready,
	output logic [ADDR_BITS-1:0]              o_addr,
	output logic [npud_pkg::PIX_W-1:0]        o_pix,
	output logic                              o_done,
	output logic                              o_last
);

	localparam int PROD_W = npud_pkg::ROW_W + npud_pkg::PITCH_W;
	localparam int SUM_W  = PROD_W + 2;
	localparam int CMP_W  = npud_pkg::DIM_W + 1;

	logic [npud_pkg::COL_W-1:0]    col_q, col_c, col_n;
	logic [npud_pkg::ROW_W-1:0]    row_q, row_c, row_n;
	logic [npud_pkg::PLANE_W-1:0]  plane_q, plane_c, plane_n;
	logic [npud_pkg::LEFT_W-1:0]   left_q, left_c, left_n;
	logic [npud_pkg::IDX_W-1:0]    idx_q;
	logic                          ovld_q;
	logic                          fire, start, done, last;
	logic [PROD_W-1:0]             prod;
	logic [SUM_W-1:0]              sum;
	logic [npud_pkg::DIM_W-1:0]    nx;
	logic                          row_wrap;

	assign fire    = q_valid && (!ovld_q || o_ready);
	assign q_pop   = fire && last;
	assign o_valid = ovld_q;

	always_comb begin
		start   = (left_q == '0);
		col_c   = start ? '0 : col_q;
		row_c   = start ? '0 : row_q;
		plane_c = start ? '0 : plane_q;
		left_c  = start ? wh : left_q;
		left_n  = left_c - npud_pkg::LEFT_W'(1);
		done    = (left_n == '0);
		last    = done || (idx_q == npud_pkg::IDX_W'(npud_pkg::NIBS - 1));

		prod = PROD_W'(row_c) * PROD_W'(cfg.pitch);
		sum  = SUM_W'(prod) + SUM_W'(col_c)
			+ (cfg.ds ? SUM_W'(plane_c) : SUM_W'(0));

		nx       = npud_pkg::DIM_W'(col_c) + npud_pkg::DIM_W'(npud_pkg::COL_STEP);
		row_wrap = (npud_pkg::DIM_W'(row_c) + npud_pkg::DIM_W'(1) >= cfg.height);
		col_n    = col_c;
		row_n    = row_c;
		plane_n  = plane_c;
		if (cfg.ds) begin
			if (CMP_W'(nx) + CMP_W'(plane_c) >= CMP_W'(cfg.width)) begin
				col_n = '0;
				if (row_wrap) begin
					row_n   = '0;
					plane_n = plane_c + npud_pkg::PLANE_W'(1);
				end else begin
					row_n = row_c + npud_pkg::ROW_W'(1);
				end
			end else begin
				col_n = nx[npud_pkg::COL_W-1:0];
			end
		end else begin
			if (npud_pkg::DIM_W'(col_c) + npud_pkg::DIM_W'(1) >= cfg.width) begin
				col_n = '0;
				row_n = row_wrap ? '0 : row_c + npud_pkg::ROW_W'(1);
			end else begin
				col_n = col_c + npud_pkg::COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			plane_q <= '0;
			left_q  <= '0;
			idx_q   <= '0;
			ovld_q  <= 1'b0;
		end else begin
			if (fire) begin
				col_q   <= col_n;
				row_q   <= row_n;
				plane_q <= plane_n;
				left_q  <= left_n;
				idx_q   <= last ? '0 : idx_q + npud_pkg::IDX_W'(1);
				ovld_q  <= 1'b1;
			end else if (o_ready) begin
				ovld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			o_addr <= ADDR_BITS'(sum);
			o_pix  <= q_data[idx_q];
			o_done <= done;
			o_last <= last;
		end
	end

endmodule

// ===== src/nibble_pixel_unpack_descramble.sv =====
// An accepted word is written into the queue; the walker then registers its first pixel and raises m_tvalid.
// Throughput: one pixel per cycle from the address walker while a word is queued and m_tready allows, so four
// pixels per word (fewer when the image ends inside a word); the walker is the limiting unit.
// The two-entry queue keeps s_tready high while the output beat waits, until both entries hold words.
// Reset (arst_n low, asynchronous): walker, queue and output valid cleared,
// registers back to width 16, height 16, pitch 16, base 1, both modes off.
module nibble_pixel_unpack_descramble #(
	parameter int ADDR_BITS = npud_pkg::ADDR_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input words
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [npud_pkg::WORD_W-1:0]       s_tdata,   // [7:0] low_byte, [15:8] high_byte
	// pixel beats
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [((ADDR_BITS+npud_pkg::PIX_W+7)/8)*8-1:0] m_tdata,
	// m_tdata: [ADDR_BITS-1:0] pixel_address, next 8 bits pixel_value, rest zero
	output logic                              m_tlast,   // image_done
	output logic                              m_tuser,   // last_of_word
	// register writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [npud_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [npud_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int TDATA_W = ((ADDR_BITS + npud_pkg::PIX_W + 7) / 8) * 8;

	npud_pkg::cfg_t                     cfg;
	logic [npud_pkg::LEFT_W-1:0]        wh;
	logic                               push, q_full, q_valid, q_pop;
	npud_pkg::pix_set_t                 push_data, q_data;
	logic [ADDR_BITS-1:0]               addr;
	logic [npud_pkg::PIX_W-1:0]         pix;

	// registers and the width-times-height product
	npud_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.wh        (wh)
	);

	// take the word and work out all four palette indices up front
	npud_front u_front (
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.cfg       (cfg),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	// hold words here so input and output stall independently
	npud_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_data  (q_data)
	);

	// step through the address walk, drop nibbles past the end of the image
	npud_back #(
		.ADDR_BITS (ADDR_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.wh      (wh),
		.q_valid (q_valid),
		.q_data  (q_data),
		.q_pop   (q_pop),
		.o_valid (m_tvalid),
		.o_ready (m_tready),
		.o_addr  (addr),
		.o_pix   (pix),
		.o_done  (m_tlast),
		.o_last  (m_tuser)
	);

	// pack the beat: address low, pixel above, zero pad to a whole byte
	assign m_tdata = TDATA_W'({pix, addr});

endmodule

// ===== src/npud_checker.sv =====
// Port-level checker for the pixel unpacker, bound to the top level.
`include "nibble_pixel_unpack_descramble_assert.svh"

module npud_checker #(
	parameter int ADDR_BITS = npud_pkg::ADDR_BITS_DEF
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            s_tvalid,
	input  logic                                            s_tready,
	input  logic                                            m_tvalid,
	input  logic                                            m_tready,
	input  logic [((ADDR_BITS+npud_pkg::PIX_W+7)/8)*8-1:0]  m_tdata,
	input  logic                                            m_tlast,
	input  logic                                            m_tuser
);

	logic [3:0] open_q;
	logic       in_beat, word_end;

	assign in_beat  = s_tvalid && s_tready;
	assign word_end = m_tvalid && m_tready && m_tuser;

	// words taken in whose last pixel has not yet gone out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else if (in_beat && !word_end) begin
			open_q <= open_q + 4'd1;
		end else if (word_end && !in_beat) begin
			open_q <= open_q - 4'd1;
		end
	end

	`NPUD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`NPUD_ASSERT_SAME(a_done_ends_word, m_tvalid && m_tlast, m_tuser)
	`NPUD_ASSERT_SAME(a_no_orphan_pixel, m_tvalid, open_q != 4'd0)
	`NPUD_ASSERT_SAME(a_open_bound, 1'b1, open_q <= 4'd3)

endmodule

bind nibble_pixel_unpack_descramble npud_checker #(
	.ADDR_BITS (ADDR_BITS)
) u_npud_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

// ===== tb/tb_top.sv =====
// Self-checking bench for the nibble pixel unpacker: directed table, then random images.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import npud_pkg::*;

	localparam int ADDR_W        = ADDR_BITS_DEF;
	localparam int MDATA_W       = ((ADDR_W + PIX_W + 7) / 8) * 8;
	localparam int STALL_LIMIT   = 2000;   // cycles with no beat on any channel
	localparam int SETTLE_CYCLES = 4;      // quiet cycles before a register write
	localparam int TAIL_CYCLES   = 8;      // wait after the last pixel for strays
	localparam int RANDOM_WORDS  = 280;
	localparam int TALL_PASS     = 3;      // random pass that runs the tall image
	localparam int MAX_REPORTS   = 10;

	// Index with no register behind it; the write must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

	typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

	// One line of the directed plan: a word to send or a register to write.
	// Where known is set, the first pixel of the word is typed in by hand.
	typedef struct {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] val;
		logic [BYTE_W-1:0]     lo;
		logic [BYTE_W-1:0]     hi;
		bit                    known;
		logic [ADDR_W-1:0]     first_addr;
		logic [PIX_W-1:0]      first_pix;
	} plan_row_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [PIX_W-1:0]  pix;
		logic              done;
		logic              word_end;
	} pixel_beat_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [WORD_W-1:0]     s_tdata;    // [7:0] low_byte, [15:8] high_byte
	logic                  m_tvalid;
	logic                  m_tready;
	logic [MDATA_W-1:0]    m_tdata;    // [21:0] pixel_address, [29:22] pixel_value
	logic                  m_tlast;    // image_done
	logic                  m_tuser;    // last_of_word
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Set during a few random passes: both sides then run without gaps.
	bit calm;

	// Pixels still owed by the block, oldest first.
	pixel_beat_t pixels_due[$];
	int bad_beats;
	int quiet_cycles;

	// Shadow of the registers and of the address walk.
	logic [DIM_W-1:0]   reg_width;
	logic [DIM_W-1:0]   reg_height;
	logic [PITCH_W-1:0] reg_pitch;
	logic [PIX_W-1:0]   reg_base;
	logic               reg_tz;
	logic               reg_ds;
	logic [COL_W-1:0]   walk_col;
	logic [ROW_W-1:0]   walk_row;
	logic [PLANE_W-1:0] walk_plane;
	logic [LEFT_W-1:0]  walk_left;
	int                 images_begun;

	nibble_pixel_unpack_descramble #(
		.ADDR_BITS(ADDR_W)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic plan_row_t word_row(logic [BYTE_W-1:0] lo, logic [BYTE_W-1:0] hi,
			bit known = 1'b0, logic [ADDR_W-1:0] a = '0, logic [PIX_W-1:0] p = '0);
		plan_row_t r;
		r = '{kind: ROW_WORD, idx: '0, val: '0, lo: lo, hi: hi, known: known,
			first_addr: a, first_pix: p};
		return r;
	endfunction

	function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] idx,
			logic [CFG_DATA_W-1:0] val);
		plan_row_t r;
		r = '{kind: ROW_REG, idx: idx, val: val, lo: '0, hi: '0, known: 1'b0,
			first_addr: '0, first_pix: '0};
		return r;
	endfunction

	task automatic note_fail(input string what);
		if (bad_beats < MAX_REPORTS)
			$display("[%0t] %s", $realtime, what);
		bad_beats++;
	endtask

	// Turn one accepted word into the pixels it owes and queue them.
	task automatic unpack_word(input logic [BYTE_W-1:0] lo, input logic [BYTE_W-1:0] hi,
			output int made);
		logic [NIB_W-1:0] nib [NIBS];
		int unsigned w;
		int unsigned h;
		int unsigned addr;
		int unsigned nx;
		pixel_beat_t beat;
		int i;

		nib[0] = hi[7:4];
		nib[1] = hi[3:0];
		nib[2] = lo[7:4];
		nib[3] = lo[3:0];
		// Saturate the dimensions into 1..1024.
		w = (reg_width == '0) ? 1 : ((reg_width > DIM_MAX) ? DIM_MAX : 32'(reg_width));
		h = (reg_height == '0) ? 1 : ((reg_height > DIM_MAX) ? DIM_MAX : 32'(reg_height));
		made = 0;

		// A word arriving with no image open starts the next one.
		if (walk_left == '0) begin
			walk_left = LEFT_W'(w * h);
			walk_col = '0;
			walk_row = '0;
			walk_plane = '0;
			images_begun++;
		end

		for (i = 0; i < NIBS && walk_left != '0; i++) begin
			if (reg_tz && nib[i] == '0)
				beat.pix = '0;
			else
				beat.pix = PIX_W'(32'(nib[i]) + 32'(reg_base) - 1);
			addr = 32'(walk_row) * 32'(reg_pitch) + 32'(walk_col);
			if (reg_ds)
				addr += 32'(walk_plane);
			beat.addr = addr[ADDR_W-1:0];
			walk_left--;
			beat.done = (walk_left == '0);
			beat.word_end = 1'b0;
			pixels_due.push_back(beat);
			made++;

			if (reg_ds) begin
				// Interleaved walk: step by four, next plane after the last row.
				nx = 32'(walk_col) + COL_STEP;
				if (nx + 32'(walk_plane) >= w) begin
					walk_col = '0;
					if (32'(walk_row) + 1 >= h) begin
						walk_row = '0;
						walk_plane++;
					end else begin
						walk_row++;
					end
				end else begin
					walk_col = COL_W'(nx);
				end
			end else if (32'(walk_col) + 1 >= w) begin
				walk_col = '0;
				walk_row = (32'(walk_row) + 1 >= h) ? '0 : walk_row + 1'b1;
			end else begin
				walk_col++;
			end
		end

		// Flag the last pixel this word produced.
		if (made > 0) begin
			beat = pixels_due.pop_back();
			beat.word_end = 1'b1;
			pixels_due.push_back(beat);
		end
	endtask

	// Offer one word, hold it until the block takes it, then predict.
	// Leave s_tvalid high afterwards so back-to-back words need no toggle.
	task automatic send_word(input logic [BYTE_W-1:0] lo, input logic [BYTE_W-1:0] hi,
			output int made);
		while (!calm && $urandom_range(0, 99) < 12) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {hi, lo};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		unpack_word(lo, hi, made);
	endtask

	// Write a register only once every owed pixel is out and the block has settled.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		s_tvalid <= 1'b0;
		while (pixels_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_WIDTH:  reg_width = val[DIM_W-1:0];
			CFG_HEIGHT: reg_height = val[DIM_W-1:0];
			CFG_PITCH:  reg_pitch = val[PITCH_W-1:0];
			CFG_BASE:   reg_base = val[PIX_W-1:0];
			CFG_TZ:     reg_tz = val[0];
			CFG_DS:     reg_ds = val[0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	// Pixel sink: stall at random except in calm passes.
	always @(posedge clk)
		m_tready <= calm || ($urandom_range(0, 99) >= 12);

	// Compare each pixel beat with the oldest one owed.
	always @(posedge clk) begin : watch_pixels
		pixel_beat_t want;
		logic [ADDR_W-1:0] got_addr;
		logic [PIX_W-1:0] got_pix;

		if (arst_n && m_tvalid && m_tready) begin
			got_addr = m_tdata[ADDR_W-1:0];
			got_pix = m_tdata[ADDR_W +: PIX_W];
			if (pixels_due.size() == 0) begin
				note_fail($sformatf("stray pixel beat addr %0h value %0h done %0b word_end %0b",
					got_addr, got_pix, m_tlast, m_tuser));
			end else begin
				want = pixels_due.pop_front();
				if (got_addr !== want.addr || got_pix !== want.pix ||
						m_tlast !== want.done || m_tuser !== want.word_end)
					note_fail($sformatf({"pixel mismatch: addr %0h/%0h value %0h/%0h ",
						"done %0b/%0b word_end %0b/%0b (expected/actual)"},
						want.addr, got_addr, want.pix, got_pix, want.done, m_tlast,
						want.word_end, m_tuser));
			end
		end
	end

	// Watchdog: end the run if no beat moves on any channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		plan_row_t plan[$];
		pixel_beat_t fixed;
		cfg_idx_t pick;
		logic [WORD_W-1:0] data;
		int made;
		int first;
		int pass_no;
		int words_sent;
		int begun_at;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		calm = 1'b0;
		bad_beats = 0;
		quiet_cycles = 0;
		reg_width = DIM_W'(16);
		reg_height = DIM_W'(16);
		reg_pitch = PITCH_W'(16);
		reg_base = PIX_W'(1);
		reg_tz = 1'b0;
		reg_ds = 1'b0;
		walk_col = '0;
		walk_row = '0;
		walk_plane = '0;
		walk_left = '0;
		images_begun = 0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed plan. Reset values first: 16x16 raster, pitch 16, base 1.
		plan.push_back(word_row(8'h00, 8'h00, 1'b1, 'd0, 8'h00));   // all-zero word
		plan.push_back(word_row(8'hFF, 8'hFF, 1'b1, 'd4, 8'h0F));   // all-ones word
		plan.push_back(reg_row(CFG_BASE, 'd0));                     // zero base wraps to FF
		plan.push_back(word_row(8'h00, 8'h01, 1'b1, 'd8, 8'hFF));
		plan.push_back(reg_row(CFG_BASE, 'd255));
		plan.push_back(word_row(8'hFF, 8'hFF, 1'b1, 'd12, 8'h0D));
		plan.push_back(reg_row(CFG_TZ, 'd1));                       // color key on
		plan.push_back(word_row(8'hF0, 8'h0F, 1'b1, 'd16, 8'h00));  // row 1 begins here
		// Change dimensions mid-image, beyond their limits on both sides.
		plan.push_back(reg_row(CFG_WIDTH, 'd0));
		plan.push_back(reg_row(CFG_HEIGHT, 'd2047));
		plan.push_back(reg_row(CFG_PITCH, 'd8191));
		plan.push_back(word_row(8'hA5, 8'h5A));
		plan.push_back(reg_row(CFG_DS, 'd1));
		plan.push_back(word_row(8'hC3, 8'h3C));
		plan.push_back(reg_row(CFG_WIDTH, 'd1024));
		plan.push_back(reg_row(CFG_PITCH, 'd0));
		plan.push_back(word_row(8'h69, 8'h96));
		plan.push_back(reg_row(CFG_SPARE, 'h1FFF));
		plan.push_back(word_row(8'h34, 8'h12));
		// Back to a small image before the random part.
		plan.push_back(reg_row(CFG_WIDTH, 'd5));
		plan.push_back(reg_row(CFG_HEIGHT, 'd3));
		plan.push_back(reg_row(CFG_PITCH, 'd7));
		plan.push_back(reg_row(CFG_TZ, 'd0));
		plan.push_back(reg_row(CFG_DS, 'd0));

		foreach (plan[k]) begin
			if (plan[k].kind == ROW_REG) begin
				write_reg(plan[k].idx, plan[k].val);
			end else begin
				send_word(plan[k].lo, plan[k].hi, made);
				// Swap in the hand-typed first pixel where there is one.
				if (plan[k].known && made > 0) begin
					first = pixels_due.size() - made;
					fixed = pixels_due[first];
					fixed.addr = plan[k].first_addr;
					fixed.pix = plan[k].first_pix;
					pixels_due[first] = fixed;
				end
			end
		end

		// Random passes: a few register writes while idle, then a burst of words.
		pass_no = 0;
		words_sent = 0;
		while (words_sent < RANDOM_WORDS) begin
			calm = (pass_no >= 6 && pass_no <= 8);
			if (pass_no == TALL_PASS) begin
				// One column, many rows at full pitch: the address passes its wrap.
				write_reg(CFG_WIDTH, 'd1);
				write_reg(CFG_HEIGHT, 'd520);
				write_reg(CFG_PITCH, 'd8191);
				write_reg(CFG_DS, CFG_DATA_W'($urandom_range(0, 1)));
				begun_at = images_begun;
				// Finish whatever image is open, then the whole tall one.
				do begin
					data = WORD_W'($urandom);
					send_word(data[7:0], data[15:8], made);
					words_sent++;
				end while (!(images_begun > begun_at && walk_left == '0));
				write_reg(CFG_HEIGHT, CFG_DATA_W'($urandom_range(1, 8)));
			end else begin
				repeat ($urandom_range(1, 3)) begin
					pick = cfg_idx_t'($urandom_range(0, 5));
					case (pick)
						CFG_WIDTH:  write_reg(pick, ($urandom_range(0, 7) == 0) ?
							CFG_DATA_W'($urandom_range(13, 40)) :
							CFG_DATA_W'($urandom_range(1, 12)));
						CFG_HEIGHT: write_reg(pick, CFG_DATA_W'($urandom_range(1, 8)));
						CFG_PITCH:  write_reg(pick, ($urandom_range(0, 1) == 0) ?
							CFG_DATA_W'($urandom_range(0, 31)) :
							CFG_DATA_W'($urandom_range(0, 8191)));
						CFG_BASE:   write_reg(pick, CFG_DATA_W'($urandom_range(0, 255)));
						default:    write_reg(pick, CFG_DATA_W'($urandom_range(0, 1)));
					endcase
				end
				repeat ($urandom_range(3, 20)) begin
					data = WORD_W'($urandom);
					// Now and then clear a nibble so the color key gets hit.
					if ($urandom_range(0, 3) == 0)
						data[4 * $urandom_range(0, 3) +: 4] = '0;
					send_word(data[7:0], data[15:8], made);
					words_sent++;
				end
			end
			pass_no++;
		end

		// Drop valid, drain every owed pixel, then watch for strays.
		s_tvalid <= 1'b0;
		calm = 1'b0;
		while (pixels_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (bad_beats == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
